>>> hdl/lru_result_cache_with_invalidate_unit_macros.svh
// ----------------------------------------------------------------------------
// LRU result cache assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_RESULT_CACHE_WITH_INVALIDATE_UNIT_MACROS_SVH
`define LRU_RESULT_CACHE_WITH_INVALIDATE_UNIT_MACROS_SVH

// same-cycle implication
`define LRCI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrci: assertion failed");

// next-cycle implication
`define LRCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrci: assertion failed");

`endif

>>> hdl/lrci_pkg.sv
// ----------------------------------------------------------------------------
// lrci_pkg
// Constants, codes and control/status types of the LRU result cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lrci_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int SCAN_W      = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W       = 6;
    localparam int MAX_RESULTS = TABLE_SLOTS + 1;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int KEY_W        = 32;
    localparam int STAMP_W      = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 3;
    localparam int SLOT_FIELD_W = 5;
    localparam int LIMIT_W      = 5;
    localparam int LIMIT_RESET  = 31;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 48;

    // actions
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INVAL  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TRIM   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_CACHED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUILD_FAILED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICTED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MARKED       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_TRIM_DONE    = 3'd7;

    // datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE     = 3'd0;
    localparam op_t OP_DROP_HIT = 3'd1;
    localparam op_t OP_HIT      = 3'd2;
    localparam op_t OP_INSERT   = 3'd3;
    localparam op_t OP_EVICT    = 3'd4;
    localparam op_t OP_MARK     = 3'd5;
    localparam op_t OP_NOTE     = 3'd6;

    // how the last flag of a result is decided
    typedef logic [1:0] last_mode_t;
    localparam last_mode_t LAST_NO    = 2'd0;
    localparam last_mode_t LAST_YES   = 2'd1;
    localparam last_mode_t LAST_IFFIT = 2'd2;

    typedef struct packed {
        logic                  take;
        logic                  scan_start;
        logic                  scan_oldest;
        op_t                   op;
        logic [STATUS_W-1:0]   note_status;
        last_mode_t            last_mode;
    } cmd_t;

    typedef struct packed {
        logic                  scan_busy;
        logic                  hit_found;
        logic                  hit_drop;
        logic                  free_found;
        logic                  best_found;
        logic                  over_limit;
        logic                  out_free;
        logic [ACTION_W-1:0]   action;
        logic                  fails;
        logic                  nocache;
    } sts_t;

endpackage

`default_nettype wire

>>> hdl/lrci_dp.sv
// ----------------------------------------------------------------------------
// lrci_dp
// Datapath: slot memory, valid/stale bits, scan engine, counters, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module lrci_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lrci_pkg::cmd_t                     cmd,
    output lrci_pkg::sts_t                          sts,
    input  wire logic                               in_accept,
    input  wire logic [lrci_pkg::ACTION_W-1:0]      in_action,
    input  wire logic [lrci_pkg::IN_TDATA_W-1:0]    in_data,
    input  wire logic                               cfg_valid,
    input  wire logic [lrci_pkg::LIMIT_W-1:0]       cfg_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lrci_pkg::STATUS_W-1:0]           out_status,
    output logic [lrci_pkg::OUT_TDATA_W-1:0]        out_data,
    output logic                                    out_last
);
    import lrci_pkg::*;

    localparam int MEM_W = STAMP_W + KEY_W;

    // slot memory: {stamp, key}
    logic [MEM_W-1:0]       mem [TABLE_SLOTS];
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]       mem_wdata;
    logic [MEM_W-1:0]       rd_data_reg;

    // latched item
    logic [ACTION_W-1:0]    act_reg;
    logic [KEY_W-1:0]       key_reg;
    logic                   blocked_reg, reval_reg, nocache_reg, fails_reg;

    // table state
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [TABLE_SLOTS-1:0] stale_reg, stale_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [STAMP_W-1:0]     gstamp_reg, gstamp_next, gstamp_adv;
    logic [LIMIT_W-1:0]     max_reg, max_next;

    // scan engine
    logic [SCAN_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                   scan_oldest_reg, scan_oldest_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0]      cmp_idx_reg;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   scan_run;
    logic [KEY_W-1:0]       rd_key;
    logic [STAMP_W-1:0]     rd_stamp;

    // scan results
    logic                   hit_vld_reg, hit_vld_next;
    logic [SLOT_W-1:0]      hit_slot_reg, hit_slot_next;
    logic                   free_vld_reg, free_vld_next;
    logic [SLOT_W-1:0]      free_slot_reg, free_slot_next;
    logic                   best_vld_reg, best_vld_next;
    logic [SLOT_W-1:0]      best_slot_reg, best_slot_next;
    logic [STAMP_W-1:0]     best_stamp_reg, best_stamp_next;
    logic [KEY_W-1:0]       best_key_reg, best_key_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SLOT_FIELD_W-1:0] out_slot_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [CNT_W-1:0]       out_cnt_reg;
    logic                   out_last_reg;
    logic [RES_W-1:0]       res_cnt_reg, res_cnt_next;

    // put request
    logic                   put_en;
    logic [STATUS_W-1:0]    put_status;
    logic [SLOT_W-1:0]      put_slot;
    logic [KEY_W-1:0]       put_key;
    logic                   put_last;
    logic                   put_emit;

    assign scan_run  = (32'(scan_cnt_reg) < TABLE_SLOTS);
    assign rd_addr   = scan_cnt_reg[SLOT_W-1:0];
    assign rd_key    = rd_data_reg[KEY_W-1:0];
    assign rd_stamp  = rd_data_reg[MEM_W-1:KEY_W];
    assign gstamp_adv = (gstamp_reg == '1) ? gstamp_reg : gstamp_reg + 1'b1;
    assign put_emit  = put_en && (32'(res_cnt_reg) < MAX_RESULTS);

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (scan_run)
        begin
            rd_data_reg <= mem[rd_addr];
            cmp_idx_reg <= rd_addr;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg     <= in_action;
            key_reg     <= in_data[KEY_W-1:0];
            blocked_reg <= in_data[KEY_W];
            reval_reg   <= in_data[KEY_W+1];
            nocache_reg <= in_data[KEY_W+2];
            fails_reg   <= in_data[KEY_W+3];
        end
    end

    // next-state logic: scan compare, table operations, result load
    always_comb
    begin
        valid_next       = valid_reg;
        stale_next       = stale_reg;
        count_next       = count_reg;
        gstamp_next      = gstamp_reg;
        max_next         = cfg_valid ? cfg_data : max_reg;
        scan_cnt_next    = scan_run ? scan_cnt_reg + 1'b1 : scan_cnt_reg;
        scan_oldest_next = scan_oldest_reg;
        cmp_vld_next     = scan_run;
        hit_vld_next     = hit_vld_reg;
        hit_slot_next    = hit_slot_reg;
        free_vld_next    = free_vld_reg;
        free_slot_next   = free_slot_reg;
        best_vld_next    = best_vld_reg;
        best_slot_next   = best_slot_reg;
        best_stamp_next  = best_stamp_reg;
        best_key_next    = best_key_reg;
        mem_we           = 1'b0;
        mem_waddr        = hit_slot_reg;
        mem_wdata        = {gstamp_adv, key_reg};
        put_en           = 1'b0;
        put_status       = cmd.note_status;
        put_slot         = '0;
        put_key          = '0;

        // compare stage of a running scan
        if (cmp_vld_reg)
        begin
            if (scan_oldest_reg)
            begin
                if (valid_reg[cmp_idx_reg] && (!best_vld_reg || rd_stamp < best_stamp_reg))
                begin
                    best_vld_next   = 1'b1;
                    best_slot_next  = cmp_idx_reg;
                    best_stamp_next = rd_stamp;
                    best_key_next   = rd_key;
                end
            end
            else
            begin
                if (valid_reg[cmp_idx_reg] && rd_key == key_reg && !hit_vld_reg)
                begin
                    hit_vld_next  = 1'b1;
                    hit_slot_next = cmp_idx_reg;
                end
                if (!valid_reg[cmp_idx_reg] && !free_vld_reg)
                begin
                    free_vld_next  = 1'b1;
                    free_slot_next = cmp_idx_reg;
                end
            end
        end

        // scan start
        if (cmd.scan_start)
        begin
            scan_cnt_next    = '0;
            cmp_vld_next     = 1'b0;
            scan_oldest_next = cmd.scan_oldest;
            if (cmd.scan_oldest)
            begin
                best_vld_next = 1'b0;
            end
            else
            begin
                hit_vld_next   = 1'b0;
                free_vld_next  = 1'b0;
                free_slot_next = '0;
            end
        end

        // table operations
        case (cmd.op)
            OP_DROP_HIT:
            begin
                valid_next[hit_slot_reg] = 1'b0;
                stale_next[hit_slot_reg] = 1'b0;
                count_next   = count_reg - 1'b1;
                hit_vld_next = 1'b0;
                if (!free_vld_reg || hit_slot_reg < free_slot_reg)
                begin
                    free_vld_next  = 1'b1;
                    free_slot_next = hit_slot_reg;
                end
                put_en     = 1'b1;
                put_status = ST_EVICTED;
                put_slot   = hit_slot_reg;
                put_key    = key_reg;
            end
            OP_HIT:
            begin
                gstamp_next = gstamp_adv;
                mem_we      = 1'b1;
                mem_waddr   = hit_slot_reg;
                put_en      = 1'b1;
                put_status  = ST_HIT;
                put_slot    = hit_slot_reg;
                put_key     = key_reg;
            end
            OP_INSERT:
            begin
                gstamp_next = gstamp_adv;
                mem_we      = 1'b1;
                mem_waddr   = free_slot_reg;
                valid_next[free_slot_reg] = 1'b1;
                stale_next[free_slot_reg] = 1'b0;
                count_next  = count_reg + 1'b1;
                put_en      = 1'b1;
                put_status  = ST_INSERTED;
                put_slot    = free_slot_reg;
                put_key     = key_reg;
            end
            OP_EVICT:
            begin
                valid_next[best_slot_reg] = 1'b0;
                stale_next[best_slot_reg] = 1'b0;
                count_next     = count_reg - 1'b1;
                free_vld_next  = 1'b1;
                free_slot_next = best_slot_reg;
                put_en         = 1'b1;
                put_status     = ST_EVICTED;
                put_slot       = best_slot_reg;
                put_key        = best_key_reg;
            end
            OP_MARK:
            begin
                stale_next[hit_slot_reg] = 1'b1;
                put_en     = 1'b1;
                put_status = ST_MARKED;
                put_slot   = hit_slot_reg;
                put_key    = key_reg;
            end
            OP_NOTE:
            begin
                put_en = 1'b1;
            end
            default:
            begin
                put_en = 1'b0;
            end
        endcase
    end

    // last flag: final result by rule, or the final one kept under the cap
    always_comb
    begin
        case (cmd.last_mode)
            LAST_YES:   put_last = 1'b1;
            LAST_IFFIT: put_last = !(32'(count_next) > 32'(max_reg));
            default:    put_last = 1'b0;
        endcase
        if (32'(res_cnt_reg) == MAX_RESULTS - 1)
        begin
            put_last = 1'b1;
        end
    end

    // result counter and result register valid
    always_comb
    begin
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_accept)
        begin
            res_cnt_next = '0;
        end
        else if (put_emit)
        begin
            res_cnt_next   = res_cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            stale_reg       <= '0;
            count_reg       <= '0;
            gstamp_reg      <= '0;
            max_reg         <= LIMIT_W'(LIMIT_RESET);
            scan_cnt_reg    <= SCAN_W'(TABLE_SLOTS);
            scan_oldest_reg <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            hit_vld_reg     <= 1'b0;
            free_vld_reg    <= 1'b0;
            best_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            res_cnt_reg     <= '0;
        end
        else
        begin
            valid_reg       <= valid_next;
            stale_reg       <= stale_next;
            count_reg       <= count_next;
            gstamp_reg      <= gstamp_next;
            max_reg         <= max_next;
            scan_cnt_reg    <= scan_cnt_next;
            scan_oldest_reg <= scan_oldest_next;
            cmp_vld_reg     <= cmp_vld_next;
            hit_vld_reg     <= hit_vld_next;
            free_vld_reg    <= free_vld_next;
            best_vld_reg    <= best_vld_next;
            out_valid_reg   <= out_valid_next;
            res_cnt_reg     <= res_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_slot_reg   <= hit_slot_next;
        free_slot_reg  <= free_slot_next;
        best_slot_reg  <= best_slot_next;
        best_stamp_reg <= best_stamp_next;
        best_key_reg   <= best_key_next;
        if (put_emit)
        begin
            out_status_reg <= put_status;
            out_slot_reg   <= SLOT_FIELD_W'(put_slot);
            out_key_reg    <= put_key;
            out_cnt_reg    <= count_next;
            out_last_reg   <= put_last;
        end
    end

    // status to the controller
    always_comb
    begin
        sts.scan_busy  = scan_run || cmp_vld_reg;
        sts.hit_found  = hit_vld_reg;
        sts.hit_drop   = stale_reg[hit_slot_reg] || blocked_reg || reval_reg;
        sts.free_found = free_vld_reg;
        sts.best_found = best_vld_reg;
        sts.over_limit = (32'(count_reg) > 32'(max_reg));
        sts.out_free   = !out_valid_reg || out_ready;
        sts.action     = act_reg;
        sts.fails      = fails_reg;
        sts.nocache    = nocache_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign out_data   = OUT_TDATA_W'({out_cnt_reg, out_key_reg, out_slot_reg});

endmodule

`default_nettype wire

>>> hdl/lrci_ctrl.sv
// ----------------------------------------------------------------------------
// lrci_ctrl
// Controller: sequences search, mark, drop, hit/insert, room eviction and trim.
// ----------------------------------------------------------------------------
`default_nettype none

module lrci_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire lrci_pkg::sts_t sts,
    output lrci_pkg::cmd_t      cmd
);
    import lrci_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_SEARCH     = 4'd2;
    localparam logic [3:0] S_MARK       = 4'd3;
    localparam logic [3:0] S_DROP       = 4'd4;
    localparam logic [3:0] S_HIT        = 4'd5;
    localparam logic [3:0] S_MISS       = 4'd6;
    localparam logic [3:0] S_ROOM_SCAN  = 4'd7;
    localparam logic [3:0] S_ROOM_EVICT = 4'd8;
    localparam logic [3:0] S_INSERT     = 4'd9;
    localparam logic [3:0] S_TRIM       = 4'd10;
    localparam logic [3:0] S_TRIM_SCAN  = 4'd11;
    localparam logic [3:0] S_TRIM_EVICT = 4'd12;
    localparam logic [3:0] S_TRIM_DONE  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       is_trim;

    assign is_trim = (sts.action == ACT_TRIM);

    // state sequencing and command decode
    always_comb
    begin
        state_next      = state_reg;
        cmd.take        = 1'b0;
        cmd.scan_start  = 1'b0;
        cmd.scan_oldest = 1'b0;
        cmd.op          = OP_NONE;
        cmd.note_status = ST_NO_ENTRY;
        cmd.last_mode   = LAST_NO;

        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.action == ACT_LOOKUP || sts.action == ACT_INVAL)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SEARCH;
                end
                else if (is_trim)
                begin
                    state_next = S_TRIM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (!sts.scan_busy)
                begin
                    if (sts.action == ACT_INVAL)
                        state_next = S_MARK;
                    else if (sts.hit_found && sts.hit_drop)
                        state_next = S_DROP;
                    else if (sts.hit_found)
                        state_next = S_HIT;
                    else
                        state_next = S_MISS;
                end
            end
            S_MARK:
            begin
                if (sts.out_free)
                begin
                    cmd.op        = sts.hit_found ? OP_MARK : OP_NOTE;
                    cmd.last_mode = LAST_YES;
                    state_next    = S_IDLE;
                end
            end
            S_DROP:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_DROP_HIT;
                    state_next = S_MISS;
                end
            end
            S_HIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op        = OP_HIT;
                    cmd.last_mode = LAST_IFFIT;
                    state_next    = S_TRIM;
                end
            end
            S_MISS:
            begin
                if (sts.fails)
                begin
                    if (sts.out_free)
                    begin
                        cmd.op          = OP_NOTE;
                        cmd.note_status = ST_BUILD_FAILED;
                        cmd.last_mode   = LAST_YES;
                        state_next      = S_IDLE;
                    end
                end
                else if (sts.nocache)
                begin
                    if (sts.out_free)
                    begin
                        cmd.op          = OP_NOTE;
                        cmd.note_status = ST_NOT_CACHED;
                        cmd.last_mode   = LAST_IFFIT;
                        state_next      = S_TRIM;
                    end
                end
                else if (sts.free_found)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.scan_start  = 1'b1;
                    cmd.scan_oldest = 1'b1;
                    state_next      = S_ROOM_SCAN;
                end
            end
            S_ROOM_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    state_next = sts.best_found ? S_ROOM_EVICT : S_INSERT;
                end
            end
            S_ROOM_EVICT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EVICT;
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                if (sts.out_free)
                begin
                    cmd.op        = OP_INSERT;
                    cmd.last_mode = LAST_IFFIT;
                    state_next    = S_TRIM;
                end
            end
            S_TRIM:
            begin
                if (sts.over_limit)
                begin
                    cmd.scan_start  = 1'b1;
                    cmd.scan_oldest = 1'b1;
                    state_next      = S_TRIM_SCAN;
                end
                else
                begin
                    state_next = is_trim ? S_TRIM_DONE : S_IDLE;
                end
            end
            S_TRIM_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    if (sts.best_found)
                        state_next = S_TRIM_EVICT;
                    else
                        state_next = is_trim ? S_TRIM_DONE : S_IDLE;
                end
            end
            S_TRIM_EVICT:
            begin
                if (sts.out_free)
                begin
                    cmd.op        = OP_EVICT;
                    cmd.last_mode = is_trim ? LAST_NO : LAST_IFFIT;
                    state_next    = S_TRIM;
                end
            end
            S_TRIM_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op          = OP_NOTE;
                    cmd.note_status = ST_TRIM_DONE;
                    cmd.last_mode   = LAST_YES;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lru_result_cache_with_invalidate_unit.sv
// ----------------------------------------------------------------------------
// LRU result cache with invalidate
// Fully associative 32-slot result cache keyed by a 32-bit key, with
// timestamp LRU eviction, stale marking and a configurable entry limit.
// ----------------------------------------------------------------------------
// One item is handled at a time. Every lookup and invalidate walks the slot
// memory once, one slot per cycle through its single read port. Each eviction
// (making room on a full table, or trimming down to max_entries) walks it
// again to find the oldest stamp. Slot valid and stale bits are flip-flops
// cleared by reset, so no clearing pass is needed after reset. The user must
// write the entry limit on the cfg channel only while the block is idle; the
// block itself does not enforce this. The limit takes effect on the next
// lookup or trim.
`default_nettype none

module lru_result_cache_with_invalidate_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // key[31:0], blocked[32], revalidate[33], nocache[34], build_fails[35]
    input  wire logic [lrci_pkg::IN_TDATA_W-1:0]    s_tdata,
    // action[1:0]
    input  wire logic [lrci_pkg::ACTION_W-1:0]      s_tuser,
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // slot[4:0], entry_key[36:5], entries_now[42:37]
    output logic [lrci_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // status[2:0]
    output logic [lrci_pkg::STATUS_W-1:0]           m_tuser,
    output logic                                    m_tlast,
    // max_entries write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lrci_pkg::LIMIT_W-1:0]       cfg_data
);
    import lrci_pkg::*;

    `include "lru_result_cache_with_invalidate_unit_macros.svh"

    cmd_t cmd;
    sts_t sts;
    logic in_accept;

    assign s_tready  = cmd.take;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    lrci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrci_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_accept  (in_accept),
        .in_action  (s_tuser),
        .in_data    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

    // an accepted item keeps the input closed for at least the next cycle
    `LRCI_ASSERT_NEXT(a_busy_after_take, in_accept, !s_tready)

    // terminal statuses always close their item
    `LRCI_ASSERT_SAME(a_terminal_last,
        m_tvalid && (m_tuser == ST_BUILD_FAILED || m_tuser == ST_MARKED ||
                     m_tuser == ST_NO_ENTRY || m_tuser == ST_TRIM_DONE),
        m_tlast)

    // table operations never overlap a running scan
    `LRCI_ASSERT_SAME(a_no_op_during_scan, sts.scan_busy, cmd.op == OP_NONE)

endmodule

`default_nettype wire

>>> sim/lru_result_cache_with_invalidate_unit_checker.sv
// ----------------------------------------------------------------------------
// LRU result cache checker
// Watches the input, result and limit channels, mirrors the cache table,
// predicts the result items of every accepted input item and compares them
// in order with the result items the block delivers.
// ----------------------------------------------------------------------------

module lru_result_cache_with_invalidate_unit_checker
    import lrci_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0]      s_tdata,
    input  wire logic [ACTION_W-1:0]        s_tuser,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [OUT_TDATA_W-1:0]     m_tdata,
    input  wire logic [STATUS_W-1:0]        m_tuser,
    input  wire logic                       m_tlast,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [LIMIT_W-1:0]         cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              results_seen,
    output int                              evicts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // input flag positions above the key
    localparam int BLOCKED_BIT = KEY_W;
    localparam int REVAL_BIT   = KEY_W + 1;
    localparam int NOCACHE_BIT = KEY_W + 2;
    localparam int FAILS_BIT   = KEY_W + 3;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [KEY_W-1:0]        key;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } cache_result_t;

    // mirror of the cache table
    logic               mirror_valid [TABLE_SLOTS];
    logic               mirror_stale [TABLE_SLOTS];
    logic [KEY_W-1:0]   mirror_key   [TABLE_SLOTS];
    logic [STAMP_W-1:0] mirror_stamp [TABLE_SLOTS];
    logic [STAMP_W-1:0] now_stamp;
    logic [CNT_W-1:0]   live_count;
    logic [LIMIT_W-1:0] entry_limit;

    // predicted result items, oldest first
    cache_result_t results_q[$];
    cache_result_t held;
    bit            have_held;
    int            item_count;
    int            errs;
    int            n_results;
    int            n_evicts;

    // lowest valid slot holding key k, -1 when absent
    function automatic int slot_of_key(logic [KEY_W-1:0] k);
        int found;
        int i;
        found = -1;
        for (i = TABLE_SLOTS - 1; i >= 0; i--)
            if (mirror_valid[i] && mirror_key[i] == k)
                found = i;
        return found;
    endfunction

    // valid slot with the lowest stamp, lowest slot on ties
    function automatic int oldest_slot();
        int best;
        int i;
        best = -1;
        for (i = 0; i < TABLE_SLOTS; i++)
            if (mirror_valid[i] && (best < 0 || mirror_stamp[i] < mirror_stamp[best]))
                best = i;
        return best;
    endfunction

    // one result item; the previous one is released so the final one can get last
    task automatic emit(logic [STATUS_W-1:0] st, int s, logic [KEY_W-1:0] k);
        cache_result_t r;
        if (item_count < MAX_RESULTS)
        begin
            r.status = st;
            r.slot   = s[SLOT_FIELD_W-1:0];
            r.key    = k;
            r.count  = live_count;
            r.last   = 1'b0;
            if (have_held)
                results_q.push_back(held);
            held      = r;
            have_held = 1'b1;
            item_count++;
        end
    endtask

    task automatic evict_slot(int s);
        mirror_valid[s] = 1'b0;
        mirror_stale[s] = 1'b0;
        if (live_count > 0)
            live_count--;
        emit(ST_EVICTED, s, mirror_key[s]);
    endtask

    task automatic bump_stamp();
        if (now_stamp != '1)
            now_stamp++;
    endtask

    task automatic trim_to_limit();
        int s;
        while (live_count > entry_limit)
        begin
            s = oldest_slot();
            if (s < 0)
                break;
            evict_slot(s);
        end
    endtask

    task automatic predict_lookup(logic [KEY_W-1:0] k, logic blk, logic rv,
                                  logic nc, logic bf);
        int s;
        int free_s;
        int i;
        s = slot_of_key(k);
        // stale entry or forced rebuild: drop, then treat as a miss
        if (s >= 0 && (mirror_stale[s] || blk || rv))
        begin
            evict_slot(s);
            s = -1;
        end
        if (s >= 0)
        begin
            bump_stamp();
            mirror_stamp[s] = now_stamp;
            emit(ST_HIT, s, k);
            trim_to_limit();
        end
        else if (bf)
        begin
            emit(ST_BUILD_FAILED, 0, '0);
        end
        else
        begin
            if (nc)
            begin
                emit(ST_NOT_CACHED, 0, '0);
            end
            else
            begin
                free_s = -1;
                for (i = 0; i < TABLE_SLOTS; i++)
                    if (!mirror_valid[i] && free_s < 0)
                        free_s = i;
                // full table: make room by evicting the oldest entry
                if (free_s < 0)
                begin
                    free_s = oldest_slot();
                    if (free_s < 0)
                        free_s = 0;
                    else
                        evict_slot(free_s);
                end
                bump_stamp();
                mirror_valid[free_s] = 1'b1;
                mirror_stale[free_s] = 1'b0;
                mirror_key[free_s]   = k;
                mirror_stamp[free_s] = now_stamp;
                live_count++;
                emit(ST_INSERTED, free_s, k);
            end
            trim_to_limit();
        end
    endtask

    task automatic predict_item(logic [ACTION_W-1:0] act, logic [IN_TDATA_W-1:0] d);
        int s;
        item_count = 0;
        have_held  = 1'b0;
        case (act)
            ACT_LOOKUP:
                predict_lookup(d[KEY_W-1:0], d[BLOCKED_BIT], d[REVAL_BIT],
                               d[NOCACHE_BIT], d[FAILS_BIT]);
            ACT_INVAL:
            begin
                s = slot_of_key(d[KEY_W-1:0]);
                if (s >= 0)
                begin
                    mirror_stale[s] = 1'b1;
                    emit(ST_MARKED, s, d[KEY_W-1:0]);
                end
                else
                begin
                    emit(ST_NO_ENTRY, 0, '0);
                end
            end
            ACT_TRIM:
            begin
                trim_to_limit();
                emit(ST_TRIM_DONE, 0, '0);
            end
            default: ;
        endcase
        if (have_held)
        begin
            held.last = 1'b1;
            results_q.push_back(held);
            have_held = 1'b0;
        end
    endtask

    task automatic check_result();
        cache_result_t             want;
        logic [SLOT_FIELD_W-1:0]   got_slot;
        logic [KEY_W-1:0]          got_key;
        logic [CNT_W-1:0]          got_cnt;
        got_slot = m_tdata[0 +: SLOT_FIELD_W];
        got_key  = m_tdata[SLOT_FIELD_W +: KEY_W];
        got_cnt  = m_tdata[SLOT_FIELD_W + KEY_W +: CNT_W];
        n_results++;
        if (m_tuser == ST_EVICTED)
            n_evicts++;
        if (results_q.size() == 0)
        begin
            errs++;
            if (errs <= 10)
                $display("unexpected result item: status %0d slot %0d key %h entries %0d last %0b",
                         m_tuser, got_slot, got_key, got_cnt, m_tlast);
        end
        else
        begin
            want = results_q.pop_front();
            if (want.status != m_tuser || want.slot != got_slot || want.key != got_key ||
                want.count != got_cnt || want.last != m_tlast)
            begin
                errs++;
                if (errs <= 10)
                    $display({"mismatch (expected/actual): status %0d/%0d slot %0d/%0d ",
                              "key %h/%h entries %0d/%0d last %0b/%0b"},
                             want.status, m_tuser, want.slot, got_slot, want.key, got_key,
                             want.count, got_cnt, want.last, m_tlast);
            end
        end
    endtask

    // track handshakes; outputs move with nonblocking updates
    always @(posedge clk or negedge rst_n)
    begin : track
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < TABLE_SLOTS; i++)
            begin
                mirror_valid[i] = 1'b0;
                mirror_stale[i] = 1'b0;
                mirror_key[i]   = '0;
                mirror_stamp[i] = '0;
            end
            now_stamp   = '0;
            live_count  = '0;
            entry_limit = LIMIT_W'(LIMIT_RESET);
            results_q.delete();
            have_held   = 1'b0;
            errs        = 0;
            n_results   = 0;
            n_evicts    = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
            evicts_seen  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                entry_limit = cfg_data;
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_result();
            fail_count   <= errs;
            pending      <= results_q.size();
            results_seen <= n_results;
            evicts_seen  <= n_evicts;
        end
    end

endmodule

>>> sim/lru_result_cache_with_invalidate_unit_tb.sv
// ----------------------------------------------------------------------------
// LRU result cache testbench
// Drives directed and random lookup, invalidate and trim items through
// several entry limits with random idling on both sides and a long result
// stall; a checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module lru_result_cache_with_invalidate_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrci_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_SIZE    = 48;

    // request flag bits {build_fails, nocache, revalidate, blocked}
    localparam logic [3:0] F_NONE    = 4'b0000;
    localparam logic [3:0] F_BLOCKED = 4'b0001;
    localparam logic [3:0] F_REVAL   = 4'b0010;
    localparam logic [3:0] F_NOCACHE = 4'b0100;
    localparam logic [3:0] F_FAILS   = 4'b1000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_LO = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_HI = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_C  = 32'hA5A5_5A5A;
    localparam logic [KEY_W-1:0] KEY_D  = 32'h5A5A_A5A5;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [ACTION_W-1:0]     s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [LIMIT_W-1:0]      cfg_data = '0;

    int fail_count;
    int pending;
    int results_seen;
    int evicts_seen;

    bit quiet = 1'b0;       // no idling on either side
    bit no_gap = 1'b0;      // sender offers back to back
    bit long_hold = 1'b0;   // request a long result-side stall
    int items_sent = 0;
    int limits_used = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always #6 clk = ~clk;

    lru_result_cache_with_invalidate_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lru_result_cache_with_invalidate_unit_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .evicts_seen  (evicts_seen)
    );

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one item and wait until it is taken; then maybe leave a gap
    task automatic send_item(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
                             logic [3:0] flags);
        s_tuser  <= act;
        s_tdata  <= IN_TDATA_W'({flags, k});
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (!quiet && !no_gap && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // random item: mostly lookups on a pool of recurring keys
    task automatic send_random(int span);
        int pick;
        logic [ACTION_W-1:0] act;
        logic [KEY_W-1:0] k;
        logic [3:0] flags;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            act = ACT_LOOKUP;
        else if (pick < 82)
            act = ACT_INVAL;
        else if (pick < 96)
            act = ACT_TRIM;
        else
            act = ACT_UNUSED;
        if ($urandom_range(0, 9) == 0)
            k = $urandom;
        else
            k = key_pool[$urandom_range(0, span - 1)];
        flags[0] = ($urandom_range(0, 7) == 0);
        flags[1] = ($urandom_range(0, 7) == 0);
        flags[2] = ($urandom_range(0, 5) == 0);
        flags[3] = ($urandom_range(0, 7) == 0);
        send_item(act, k, flags);
    endtask

    // drain all expected results, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limits_used++;
    endtask

    // watchdog
    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int i;
        key_pool[0] = KEY_LO;
        key_pool[1] = KEY_HI;
        for (i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: outcomes, drops, stale marks and flag combinations
        send_item(ACT_LOOKUP, KEY_LO, F_NONE);
        send_item(ACT_LOOKUP, KEY_HI, F_NONE);
        send_item(ACT_LOOKUP, KEY_LO, F_NONE);
        send_item(ACT_LOOKUP, KEY_C, F_NOCACHE);
        send_item(ACT_LOOKUP, KEY_D, F_FAILS);
        send_item(ACT_LOOKUP, KEY_HI, F_BLOCKED);
        send_item(ACT_LOOKUP, KEY_LO, F_REVAL);
        send_item(ACT_INVAL, KEY_LO, F_NONE);
        send_item(ACT_INVAL, KEY_LO, F_NONE);
        send_item(ACT_LOOKUP, KEY_LO, F_NONE);
        send_item(ACT_INVAL, KEY_C, F_NONE);
        send_item(ACT_TRIM, KEY_HI, 4'b1111);
        send_item(ACT_UNUSED, KEY_D, F_NONE);
        send_item(ACT_LOOKUP, KEY_HI, F_BLOCKED | F_FAILS);
        send_item(ACT_LOOKUP, KEY_HI, F_NOCACHE);
        send_item(ACT_LOOKUP, KEY_C, 4'b1111);
        send_item(ACT_LOOKUP, KEY_D, F_NONE);
        send_item(ACT_INVAL, KEY_D, F_NONE);
        send_item(ACT_LOOKUP, KEY_D, F_NOCACHE);
        send_item(ACT_LOOKUP, KEY_C, F_NONE);
        send_item(ACT_LOOKUP, KEY_C, F_NONE);
        settle();

        // full limit, wide key pool: the table fills up and evicts
        write_limit(LIMIT_W'(31));
        repeat (45) send_random(44);
        settle();

        // limit zero: a trim empties the whole table
        write_limit(LIMIT_W'(0));
        send_item(ACT_TRIM, KEY_LO, F_NONE);
        repeat (12) send_random(4);
        settle();

        // small limit with a long result stall in the middle
        write_limit(LIMIT_W'(3));
        repeat (15) send_random(8);
        long_hold = 1'b1;
        no_gap = 1'b1;
        repeat (8) send_random(8);
        no_gap = 1'b0;
        repeat (17) send_random(8);
        settle();

        // random limit
        write_limit(LIMIT_W'($urandom_range(1, 30)));
        repeat (40) send_random(24);
        settle();

        // final part at full limit with no idling
        write_limit(LIMIT_W'(31));
        quiet = 1'b1;
        repeat (22) send_random(40);

        settle();
        repeat (100) @(posedge clk);
        $display("Summary: %0d items over %0d limit writes, %0d result items checked",
                 items_sent, limits_used, results_seen);
        $display("Summary: %0d evictions seen, one long result stall, idle-free final phase",
                 evicts_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> lru_result_cache_with_invalidate_unit.f
+incdir+hdl
hdl/lrci_pkg.sv
hdl/lrci_dp.sv
hdl/lrci_ctrl.sv
hdl/lru_result_cache_with_invalidate_unit.sv
sim/lru_result_cache_with_invalidate_unit_checker.sv
sim/lru_result_cache_with_invalidate_unit_tb.sv
